### design/rpw_pkg.sv
// shared types and scaling constants for the pulse width capture block
package rpw_pkg;

  // frame holds at most this many results (channel field is 3 bits)
  localparam int FRAME_CAP = 8;

  // linear map 1000..2000 -> 172..1811
  localparam logic [15:0] IN_LO     = 16'd1000;
  localparam logic [10:0] OUT_LO    = 11'd172;
  localparam logic [26:0] SPAN_OUT  = 27'd1639;
  localparam logic [10:0] SERVO_MAX = 11'd2047;

  // products at or above this give quotients that saturate high once the output offset is added
  localparam logic [26:0] SAT_PROD  = 27'd1876000;

  // reciprocal of 1000 scaled by 2^31, exact for dividends below 2^21
  localparam logic [21:0] RECIP       = 22'd2147484;
  localparam int          RECIP_SHIFT = 31;

  // controller to datapath commands
  typedef struct packed {
    logic capture;
    logic cnt_clr;
    logic cnt_inc;
    logic mul_en;
    logic div_en;
    logic emit_en;
  } rpw_cmd_t;

  // datapath to controller status
  typedef struct packed {
    logic last;
  } rpw_sts_t;

endpackage

### design/rpw_ctrl.sv
// frame sequencer and output handshake control
module rpw_ctrl import rpw_pkg::*; (
  input  logic     clk,
  input  logic     rst_n,
  input  logic     in_valid,
  output logic     in_stall,
  input  logic     in_opcode,
  output logic     out_valid,
  input  logic     out_stall,
  output rpw_cmd_t cmd,
  input  rpw_sts_t sts
);

  localparam logic [1:0] ST_IDLE = 2'd0;
  localparam logic [1:0] ST_MUL  = 2'd1;
  localparam logic [1:0] ST_DIV  = 2'd2;
  localparam logic [1:0] ST_EMIT = 2'd3;

  logic [1:0] state_r, state_nxt;
  logic       out_valid_r, out_valid_nxt;
  logic       in_acc;
  logic       out_free;

  assign in_stall  = (state_r != ST_IDLE);
  assign in_acc    = in_valid && !in_stall;
  assign out_valid = out_valid_r;
  // output register empty or being taken this cycle
  assign out_free  = !out_valid_r || !out_stall;

  // next state and commands
  always_comb begin
    state_nxt   = state_r;
    cmd         = '0;
    cmd.capture = in_acc && !in_opcode;
    unique case (state_r)
      ST_IDLE: begin
        if (in_acc && in_opcode) begin
          cmd.cnt_clr = 1'b1;
          state_nxt   = ST_MUL;
        end
      end
      ST_MUL: begin
        cmd.mul_en = 1'b1;
        state_nxt  = ST_DIV;
      end
      ST_DIV: begin
        cmd.div_en = 1'b1;
        state_nxt  = ST_EMIT;
      end
      ST_EMIT: begin
        if (out_free) begin
          cmd.emit_en = 1'b1;
          if (sts.last) begin
            state_nxt = ST_IDLE;
          end else begin
            cmd.cnt_inc = 1'b1;
            state_nxt   = ST_MUL;
          end
        end
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  // output valid flag
  always_comb begin
    out_valid_nxt = out_valid_r;
    if (out_valid_r && !out_stall) begin
      out_valid_nxt = 1'b0;
    end
    if (cmd.emit_en) begin
      out_valid_nxt = 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

endmodule

### design/rpw_dpath.sv
// capture registers, scaling datapath and output payload register
module rpw_dpath import rpw_pkg::*; #(
  parameter int CHANNELS = 8
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic [2:0]  in_channel,
  input  logic        in_level,
  input  logic [31:0] in_time_us,
  input  rpw_cmd_t    cmd,
  output rpw_sts_t    sts,
  output logic [2:0]  out_channel_index,
  output logic [10:0] out_servo_value,
  output logic        out_last
);

  localparam int NCH = (CHANNELS < FRAME_CAP) ? CHANNELS : FRAME_CAP;
  localparam int CIW = (NCH > 1) ? $clog2(NCH) : 1;

  logic [31:0]    rise_r [NCH];
  logic [15:0]    pw_r   [NCH];
  logic [CIW-1:0] cnt_r, cnt_nxt;
  logic [26:0]    prod_r;
  logic           neg_r, neg_s_r;
  logic           big_r;
  logic [10:0]    q_r;
  logic [2:0]     och_r;
  logic [10:0]    oval_r;
  logic           olast_r;

  logic [CIW-1:0] eidx;
  logic           in_range;
  logic [31:0]    elapsed;
  logic [15:0]    width;
  logic           wneg;
  logic [15:0]    mag;
  logic [42:0]    recip_prod;
  logic [10:0]    val;
  logic           is_last;

  // edge capture
  assign eidx     = in_channel[CIW-1:0];
  assign in_range = ({1'b0, in_channel} < 4'(NCH));
  assign elapsed  = in_time_us - rise_r[eidx];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int i = 0; i < NCH; i++) begin
        rise_r[i] <= '0;
        pw_r[i]   <= '0;
      end
    end else if (cmd.capture && in_range) begin
      if (in_level) begin
        rise_r[eidx] <= in_time_us;
      end else begin
        pw_r[eidx] <= elapsed[15:0];
      end
    end
  end

  // frame channel counter
  assign is_last  = (cnt_r == CIW'(NCH - 1));
  assign sts.last = is_last;

  always_comb begin
    cnt_nxt = cnt_r;
    if (cmd.cnt_clr) begin
      cnt_nxt = '0;
    end else if (cmd.cnt_inc) begin
      cnt_nxt = cnt_r + 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cnt_r <= '0;
    end else begin
      cnt_r <= cnt_nxt;
    end
  end

  // stage 1: distance from 1000 times output span
  assign width = pw_r[cnt_r];
  assign wneg  = (width < IN_LO);
  assign mag   = wneg ? (IN_LO - width) : (width - IN_LO);

  always_ff @(posedge clk) begin
    if (cmd.mul_en) begin
      prod_r <= 27'(mag) * SPAN_OUT;
      neg_r  <= wneg;
    end
  end

  // stage 2: divide by 1000 through the reciprocal, flag high saturation
  assign recip_prod = 43'(prod_r[20:0]) * 43'(RECIP);

  always_ff @(posedge clk) begin
    if (cmd.div_en) begin
      q_r     <= 11'(recip_prod >> RECIP_SHIFT);
      big_r   <= (prod_r >= SAT_PROD);
      neg_s_r <= neg_r;
    end
  end

  // stage 3: apply offset with truncation toward zero and saturate
  always_comb begin
    if (neg_s_r) begin
      val = (q_r > OUT_LO) ? '0 : (OUT_LO - q_r);
    end else begin
      val = big_r ? SERVO_MAX : (q_r + OUT_LO);
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.emit_en) begin
      och_r   <= 3'(cnt_r);
      oval_r  <= val;
      olast_r <= is_last;
    end
  end

  assign out_channel_index = och_r;
  assign out_servo_value   = oval_r;
  assign out_last          = olast_r;

endmodule

### design/rc_pulse_width_to_servo_frame_core.sv
// top level: radio-control pulse width capture with servo value scaling
//
// Edge items (opcode 0) are accepted whenever no frame is in progress: a rising
// edge stores the timestamp, a falling edge stores the low 16 bits of the
// elapsed time as the channel's width; edges on channels at or above CHANNELS
// are dropped. A frame request (opcode 1) emits min(CHANNELS, 8) scaled values
// in channel order, the last one flagged. Each value passes through the
// sequencer steps (table read and span multiply, reciprocal multiply for the
// divide by 1000, offset and saturation into the output register), and in_stall
// is held high while the frame is sequenced. A result waiting in the output
// register does not block the next edge item once the frame is sequenced.
module rc_pulse_width_to_servo_frame_core import rpw_pkg::*; #(
  parameter int CHANNELS = 8
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  output logic        in_stall,
  input  logic        in_opcode,
  input  logic [2:0]  in_channel,
  input  logic        in_level,
  input  logic [31:0] in_time_us,
  output logic        out_valid,
  input  logic        out_stall,
  output logic [2:0]  out_channel_index,
  output logic [10:0] out_servo_value,
  output logic        out_last
);

  rpw_cmd_t cmd;
  rpw_sts_t sts;

  // sequencer
  rpw_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .in_opcode (in_opcode),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .cmd       (cmd),
    .sts       (sts)
  );

  // capture and scaling datapath
  rpw_dpath #(
    .CHANNELS (CHANNELS)
  ) u_dpath (
    .clk               (clk),
    .rst_n             (rst_n),
    .in_channel        (in_channel),
    .in_level          (in_level),
    .in_time_us        (in_time_us),
    .cmd               (cmd),
    .sts               (sts),
    .out_channel_index (out_channel_index),
    .out_servo_value   (out_servo_value),
    .out_last          (out_last)
  );

endmodule
